FILE: src/ipw_pkg.sv
// ----------------------------------------------------------------------------
// ipw_pkg
// Shared widths, sequencer states and control/status bundles for the
// incremental PID wheel speed unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipw_pkg;

  // field widths of the stream payloads
  localparam int WHEEL_W   = 2;
  localparam int SPEED_W   = 16;
  localparam int DT_W      = 16;
  localparam int DRIVE_W   = 7;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // register port
  localparam int ADDR_W    = 5;
  localparam int GAIN_W    = 31;
  localparam int LIMIT_W   = 23;
  localparam int THRESH_W  = 15;

  // per-wheel state
  localparam int ERR_W     = 17;
  localparam int ACC_W     = 24;

  // shared multiplier
  localparam int MUL_A_W   = 36;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  // derivative divide: magnitude width, two quotient bits per cycle
  localparam int DIV_W     = 54;

  // width of the increment / accumulator sums
  localparam int SUM_W     = 56;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_IDT,
    ST_MUL_D,
    ST_DIV_START,
    ST_DIV,
    ST_ADD_D,
    ST_CLAMP_INC,
    ST_ACC,
    ST_CLAMP_ACC,
    ST_DONE
  } ipw_state_t;

  typedef enum logic [1:0] {
    SEL_P,
    SEL_I,
    SEL_IDT,
    SEL_D
  } ipw_mul_sel_t;

  typedef struct packed {
    logic in_valid;
    logic wheel_ok;
    logic stop;
    logic dt_zero;
    logic div_done;
    logic out_free;
  } ipw_status_t;

  typedef struct packed {
    logic         ready;
    logic         load;
    logic         clear;
    ipw_mul_sel_t mul_sel;
    logic         cap_p;
    logic         cap_pi;
    logic         div_start;
    logic         add_d;
    logic         clamp_inc;
    logic         acc_add;
    logic         commit;
    logic         emit;
  } ipw_ctrl_t;

endpackage

FILE: src/ipw_mul.sv
// ----------------------------------------------------------------------------
// ipw_mul
// Shared signed multiplier with a registered product, used for the P, I and
// D terms in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipw_mul (
  input  logic                                clk,
  input  logic signed [ipw_pkg::MUL_A_W-1:0]  a,
  input  logic signed [ipw_pkg::MUL_B_W-1:0]  b,
  output logic signed [ipw_pkg::PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: src/ipw_div.sv
// ----------------------------------------------------------------------------
// ipw_div
// Iterative restoring divider, unsigned, retiring two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipw_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ipw_pkg::DIV_W-1:0]       dividend,
  input  logic [ipw_pkg::DT_W-1:0]        divisor,
  output logic [ipw_pkg::DIV_W-1:0]       quotient,
  output logic                            done
);

  localparam int DW    = ipw_pkg::DT_W;
  localparam int QW    = ipw_pkg::DIV_W;
  localparam int STEPS = QW / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [DW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      st1;
  logic [DW:0]      st2;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                           input logic [DW-1:0] d);
    logic [DW:0] s;
    logic [DW:0] diff;
    s    = {r, b};
    diff = s - {1'b0, d};
    if (s >= {1'b0, d}) begin
      return {1'b1, diff[DW-1:0]};
    end
    return {1'b0, s[DW-1:0]};
  endfunction

  always_comb begin
    st1 = div_step(rem, quo[QW-1], divisor);
    st2 = div_step(st1[DW-1:0], quo[QW-2], divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= st2[DW-1:0];
      quo <= {quo[QW-3:0], st1[DW], st2[DW]};
    end
  end

  assign quotient = quo;

endmodule

FILE: src/ipw_ctrl.sv
// ----------------------------------------------------------------------------
// ipw_ctrl
// Sequencer for one wheel tick: state read, multiplier schedule, divide,
// clamps, state write-back and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  ipw_pkg::ipw_status_t  status,
  output ipw_pkg::ipw_ctrl_t    ctrl
);

  ipw_pkg::ipw_state_t state;
  ipw_pkg::ipw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ipw_pkg::ST_IDLE: begin
        if (status.in_valid) state_next = ipw_pkg::ST_LOAD;
      end
      ipw_pkg::ST_LOAD: begin
        // unknown wheel, stop request or zero tick skip the arithmetic
        priority if (!status.wheel_ok || status.stop || status.dt_zero) begin
          state_next = ipw_pkg::ST_DONE;
        end else begin
          state_next = ipw_pkg::ST_MUL_P;
        end
      end
      ipw_pkg::ST_MUL_P:     state_next = ipw_pkg::ST_MUL_I;
      ipw_pkg::ST_MUL_I:     state_next = ipw_pkg::ST_MUL_IDT;
      ipw_pkg::ST_MUL_IDT:   state_next = ipw_pkg::ST_MUL_D;
      ipw_pkg::ST_MUL_D:     state_next = ipw_pkg::ST_DIV_START;
      ipw_pkg::ST_DIV_START: state_next = ipw_pkg::ST_DIV;
      ipw_pkg::ST_DIV: begin
        if (status.div_done) state_next = ipw_pkg::ST_ADD_D;
      end
      ipw_pkg::ST_ADD_D:     state_next = ipw_pkg::ST_CLAMP_INC;
      ipw_pkg::ST_CLAMP_INC: state_next = ipw_pkg::ST_ACC;
      ipw_pkg::ST_ACC:       state_next = ipw_pkg::ST_CLAMP_ACC;
      ipw_pkg::ST_CLAMP_ACC: state_next = ipw_pkg::ST_DONE;
      ipw_pkg::ST_DONE: begin
        if (status.out_free) state_next = ipw_pkg::ST_IDLE;
      end
      default:               state_next = ipw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = ipw_pkg::SEL_P;
    unique case (state)
      ipw_pkg::ST_IDLE:      ctrl.ready = 1'b1;
      ipw_pkg::ST_LOAD: begin
        ctrl.load  = 1'b1;
        ctrl.clear = status.wheel_ok && status.stop;
      end
      ipw_pkg::ST_MUL_P:     ctrl.mul_sel = ipw_pkg::SEL_P;
      ipw_pkg::ST_MUL_I: begin
        ctrl.cap_p   = 1'b1;
        ctrl.mul_sel = ipw_pkg::SEL_I;
      end
      ipw_pkg::ST_MUL_IDT:   ctrl.mul_sel = ipw_pkg::SEL_IDT;
      ipw_pkg::ST_MUL_D: begin
        ctrl.cap_pi  = 1'b1;
        ctrl.mul_sel = ipw_pkg::SEL_D;
      end
      ipw_pkg::ST_DIV_START: ctrl.div_start = 1'b1;
      ipw_pkg::ST_DIV:       ctrl.ready = 1'b0;
      ipw_pkg::ST_ADD_D:     ctrl.add_d = status.div_done;
      ipw_pkg::ST_CLAMP_INC: ctrl.clamp_inc = 1'b1;
      ipw_pkg::ST_ACC:       ctrl.acc_add = 1'b1;
      ipw_pkg::ST_CLAMP_ACC: ctrl.commit = 1'b1;
      ipw_pkg::ST_DONE:      ctrl.emit = status.out_free;
      default:               ctrl.ready = 1'b0;
    endcase
  end

endmodule

FILE: src/incremental_pid_wheel_speed_unit.sv
// ----------------------------------------------------------------------------
// incremental_pid_wheel_speed_unit
// Per-wheel incremental PID speed controller with an APB register port.
// ----------------------------------------------------------------------------
// Each slave transaction is one control tick for one wheel and produces
// exactly one master transaction with the wheel number and a forward drive
// of 0..100. One shared 36x32 multiplier forms the P, I and D products in
// turn, and the derivative divide by tick_dt runs in a radix-2 restoring
// divider that retires two bits of its 54-bit quotient per cycle. A stop
// request, a zero tick_dt or an unknown wheel skip the arithmetic. A
// finished result sits in the output register, so a stalled m_tready only
// holds the block once a second result is ready. The gains and limits are
// to be written over APB while the block is idle; the block itself does
// not enforce this. Per-wheel state is cleared by reset and by a target at
// or below the stop threshold for a wheel number below NUM_WHEELS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module incremental_pid_wheel_speed_unit #(
  parameter int NUM_WHEELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // wheel[1:0], target_speed[17:2], measured_speed[33:18], tick_dt[49:34]
  input  logic [ipw_pkg::IN_DATA_W-1:0]       s_tdata,
  // master stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // wheel_out[1:0], motor_drive[8:2]
  output logic [ipw_pkg::OUT_DATA_W-1:0]      m_tdata,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipw_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int WHEEL_SLOTS = 1 << ipw_pkg::WHEEL_W;
  localparam int SLOTS = (NUM_WHEELS < WHEEL_SLOTS) ? NUM_WHEELS : WHEEL_SLOTS;
  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int SW = ipw_pkg::SUM_W;
  localparam int AW = ipw_pkg::ACC_W;
  localparam int EW = ipw_pkg::ERR_W;

  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INT_GAIN   = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] REG_OUT_LIMIT  = 3'd3;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd4;
  localparam logic [2:0] REG_STOP_THR   = 3'd5;

  localparam logic [ipw_pkg::DRIVE_W-1:0] DRIVE_MAX = 7'd100;

  localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (AW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] ACC_MIN = -SW'(64'sd1 <<< (AW - 1));

  // configuration
  logic [ipw_pkg::GAIN_W-1:0]   prop_gain;
  logic [ipw_pkg::GAIN_W-1:0]   integral_gain;
  logic [ipw_pkg::GAIN_W-1:0]   deriv_gain;
  logic [ipw_pkg::LIMIT_W-1:0]  accum_limit;
  logic [ipw_pkg::LIMIT_W-1:0]  step_limit;
  logic [ipw_pkg::THRESH_W-1:0] stop_threshold;
  logic [2:0]                   reg_idx;
  logic                         cfg_wr;

  // per-wheel state
  logic signed [EW-1:0] prev_error      [SLOTS];
  logic signed [EW-1:0] prev_prev_error [SLOTS];
  logic signed [AW-1:0] output_accum    [SLOTS];

  // latched tick
  logic [ipw_pkg::WHEEL_W-1:0]        wheel_r;
  logic signed [ipw_pkg::SPEED_W-1:0] target_r;
  logic signed [ipw_pkg::SPEED_W-1:0] meas_r;
  logic [ipw_pkg::DT_W-1:0]           dt_r;
  logic [IDXW-1:0]                    idx;

  // working registers
  logic signed [EW-1:0]   e_r;
  logic signed [EW-1:0]   e1_r;
  logic signed [EW:0]     de_r;
  logic signed [EW+1:0]   dde_r;
  logic signed [AW-1:0]   acc_old_r;
  logic signed [SW-1:0]   p_r;
  logic signed [SW-1:0]   inc;
  logic signed [SW-1:0]   acc_sum;
  logic                   d_neg;

  logic signed [EW-1:0]   e_new;
  logic signed [EW-1:0]   e1_rd;
  logic signed [EW-1:0]   e2_rd;
  logic signed [SW-1:0]   acc_fin;
  logic signed [SW-1:0]   q_term;
  logic [ipw_pkg::DRIVE_W-1:0] drive;
  logic signed [AW-1:0]   acc_cur;

  // shared multiplier
  logic signed [ipw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ipw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ipw_pkg::PROD_W-1:0]  prod;
  logic [ipw_pkg::PROD_W-1:0]         prod_abs;

  // divider
  logic [ipw_pkg::DIV_W-1:0] div_q;
  logic                      div_done;

  ipw_pkg::ipw_status_t status;
  ipw_pkg::ipw_ctrl_t   ctrl;

  function automatic logic signed [SW-1:0] clamp_sym(input logic signed [SW-1:0] v,
                                                     input logic [ipw_pkg::LIMIT_W-1:0] lim);
    logic signed [SW-1:0] l;
    l = $signed({{(SW - ipw_pkg::LIMIT_W){1'b0}}, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ipw_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= 31'd13107200;
      integral_gain  <= 31'd458752000;
      deriv_gain     <= 31'd19661;
      accum_limit    <= 23'd1310720;
      step_limit     <= 23'd13107;
      stop_threshold <= 15'd82;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:  prop_gain      <= pwdata[ipw_pkg::GAIN_W-1:0];
        REG_INT_GAIN:   integral_gain  <= pwdata[ipw_pkg::GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain     <= pwdata[ipw_pkg::GAIN_W-1:0];
        REG_OUT_LIMIT:  accum_limit    <= pwdata[ipw_pkg::LIMIT_W-1:0];
        REG_STEP_LIMIT: step_limit     <= pwdata[ipw_pkg::LIMIT_W-1:0];
        REG_STOP_THR:   stop_threshold <= pwdata[ipw_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = 32'(prop_gain);
      REG_INT_GAIN:   prdata = 32'(integral_gain);
      REG_DERIV_GAIN: prdata = 32'(deriv_gain);
      REG_OUT_LIMIT:  prdata = 32'(accum_limit);
      REG_STEP_LIMIT: prdata = 32'(step_limit);
      REG_STOP_THR:   prdata = 32'(stop_threshold);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign status.in_valid = s_tvalid;
  assign status.wheel_ok = 32'(wheel_r) < NUM_WHEELS;
  assign status.stop     = $signed({target_r[ipw_pkg::SPEED_W-1], target_r})
                           <= $signed({2'b00, stop_threshold});
  assign status.dt_zero  = (dt_r == '0);
  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

  ipw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign s_tready = ctrl.ready;

  always_ff @(posedge clk) begin
    if (ctrl.ready && s_tvalid) begin
      wheel_r  <= s_tdata[1:0];
      target_r <= s_tdata[17:2];
      meas_r   <= s_tdata[33:18];
      dt_r     <= s_tdata[49:34];
    end
  end

  assign idx = wheel_r[IDXW-1:0];

  // --------------------------------------------------------------------------
  // error terms
  // --------------------------------------------------------------------------
  assign e1_rd = prev_error[idx];
  assign e2_rd = prev_prev_error[idx];
  assign e_new = EW'({target_r[ipw_pkg::SPEED_W-1], target_r}
                     - {meas_r[ipw_pkg::SPEED_W-1], meas_r});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      e_r       <= e_new;
      e1_r      <= e1_rd;
      acc_old_r <= output_accum[idx];
      de_r      <= {e_new[EW-1], e_new} - {e1_rd[EW-1], e1_rd};
      dde_r     <= {{2{e_new[EW-1]}}, e_new} - {e1_rd[EW-1], e1_rd, 1'b0}
                   + {{2{e2_rd[EW-1]}}, e2_rd};
    end
  end

  // --------------------------------------------------------------------------
  // shared multiplier schedule
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (ctrl.mul_sel)
      ipw_pkg::SEL_P: begin
        mul_a = {{(ipw_pkg::MUL_A_W - EW - 1){de_r[EW]}}, de_r};
        mul_b = {1'b0, prop_gain};
      end
      ipw_pkg::SEL_I: begin
        mul_a = {{(ipw_pkg::MUL_A_W - EW){e_r[EW-1]}}, e_r};
        mul_b = {1'b0, integral_gain};
      end
      ipw_pkg::SEL_IDT: begin
        // ki*e scaled down by 2^12, straight from the product register
        mul_a = prod[ipw_pkg::MUL_A_W+11:12];
        mul_b = {{(ipw_pkg::MUL_B_W - ipw_pkg::DT_W){1'b0}}, dt_r};
      end
      ipw_pkg::SEL_D: begin
        mul_a = {{(ipw_pkg::MUL_A_W - EW - 2){dde_r[EW+1]}}, dde_r};
        mul_b = {1'b0, deriv_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ipw_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_abs = prod[ipw_pkg::PROD_W-1] ? (ipw_pkg::PROD_W'(0) - prod) : prod;

  ipw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend ({prod_abs[ipw_pkg::DIV_W-5:0], 4'b0000}),
    .divisor  (dt_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // --------------------------------------------------------------------------
  // increment and accumulator
  // --------------------------------------------------------------------------
  assign q_term = d_neg ? $signed(~{{(SW - ipw_pkg::DIV_W){1'b0}}, div_q})
                        : $signed({{(SW - ipw_pkg::DIV_W){1'b0}}, div_q});

  always_comb begin
    if (accum_limit != '0) begin
      acc_fin = clamp_sym(acc_sum, accum_limit);
    end else if (acc_sum > ACC_MAX) begin
      acc_fin = ACC_MAX;
    end else if (acc_sum < ACC_MIN) begin
      acc_fin = ACC_MIN;
    end else begin
      acc_fin = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_p) begin
      p_r <= prod[SW+11:12];
    end
    if (ctrl.cap_pi) begin
      inc <= p_r + {{(SW + 16 - ipw_pkg::PROD_W){prod[ipw_pkg::PROD_W-1]}},
                    prod[ipw_pkg::PROD_W-1:16]};
    end else if (ctrl.add_d) begin
      // subtract the magnitude as add of its complement plus one
      inc <= inc + q_term + SW'(d_neg);
    end else if (ctrl.clamp_inc && (step_limit != '0)) begin
      inc <= clamp_sym(inc, step_limit);
    end
    if (ctrl.div_start) begin
      d_neg <= prod[ipw_pkg::PROD_W-1];
    end
    if (ctrl.acc_add) begin
      acc_sum <= {{(SW - AW){acc_old_r[AW-1]}}, acc_old_r} + inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        prev_error[i]      <= '0;
        prev_prev_error[i] <= '0;
        output_accum[i]    <= '0;
      end
    end else if (ctrl.clear) begin
      prev_error[idx]      <= '0;
      prev_prev_error[idx] <= '0;
      output_accum[idx]    <= '0;
    end else if (ctrl.commit) begin
      prev_error[idx]      <= e_r;
      prev_prev_error[idx] <= e1_r;
      output_accum[idx]    <= acc_fin[AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // result
  // --------------------------------------------------------------------------
  assign acc_cur = output_accum[idx];

  always_comb begin
    drive = '0;
    if (status.wheel_ok && !acc_cur[AW-1] && (acc_cur != '0)) begin
      if (acc_cur[AW-2:16] > DRIVE_MAX) begin
        drive = DRIVE_MAX;
      end else begin
        drive = acc_cur[AW-2:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      m_tdata <= {{(ipw_pkg::OUT_DATA_W - ipw_pkg::DRIVE_W - ipw_pkg::WHEEL_W){1'b0}},
                  drive, wheel_r};
    end
  end

endmodule
